// ----- rtl/rmbf_pkg.sv -----
// ----------------------------------------------------------------------------
// rmbf_pkg
// Shared types and constants of the ranging median batch filter.
// ----------------------------------------------------------------------------
package rmbf_pkg;

  localparam int unsigned DIST_W = 16;
  localparam int unsigned RUN_W  = 3;
  localparam logic [RUN_W-1:0] RUN_MAX = 3'd7;

  localparam logic [DIST_W-1:0] NEAR_THRESHOLD_RST = 16'd16000;

  // register index of the configuration port, byte address 4*index
  localparam int unsigned REG_INDEX_W = 1;
  localparam logic [REG_INDEX_W-1:0] REG_NEAR_THRESHOLD = 1'b0;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // from the control sequencer to the sorter
  typedef struct packed {
    logic push;   // shift a sample into the batch line
    logic start;  // sort the line once this push lands
  } sort_ctrl_t;

  // from the sorter back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;   // one-cycle pulse, line sorted
  } sort_stat_t;

endpackage

// ----- rtl/rmbf_cfg.sv -----
// ----------------------------------------------------------------------------
// rmbf_cfg
// APB register file holding the near threshold.
// ----------------------------------------------------------------------------
module rmbf_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rmbf_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [rmbf_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [rmbf_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic [rmbf_pkg::DIST_W-1:0]       near_threshold_o
);
  import rmbf_pkg::*;

  logic [DIST_W-1:0]      near_threshold_q;
  logic [REG_INDEX_W-1:0] reg_index;
  logic                   wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[APB_ADDR_W-1:2];
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_threshold_q <= NEAR_THRESHOLD_RST;
    end else if (wr_en && (reg_index == REG_NEAR_THRESHOLD)) begin
      near_threshold_q <= pwdata[DIST_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_index)
      REG_NEAR_THRESHOLD: prdata = {{(APB_DATA_W-DIST_W){1'b0}}, near_threshold_q};
      default:            prdata = '0;
    endcase
  end

  assign near_threshold_o = near_threshold_q;

endmodule

// ----- rtl/rmbf_sorter.sv -----
// ----------------------------------------------------------------------------
// rmbf_sorter
// Batch line with one shared comparator. Each pass rotates the line through
// a carry register, bubbling the largest remaining value to the tail.
// ----------------------------------------------------------------------------
module rmbf_sorter #(
  parameter int unsigned BATCH_LEN = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rmbf_pkg::sort_ctrl_t          ctrl_i,
  input  logic [rmbf_pkg::DIST_W-1:0]   sample_i,
  output rmbf_pkg::sort_stat_t          stat_o,
  output logic [rmbf_pkg::DIST_W-1:0]   median_o
);
  import rmbf_pkg::*;

  localparam int unsigned STEP_W = $clog2(BATCH_LEN + 1);
  localparam int unsigned PASS_W = $clog2(BATCH_LEN - 1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(BATCH_LEN);
  localparam logic [PASS_W-1:0] PASS_LAST = PASS_W'(BATCH_LEN - 2);

  logic [DIST_W-1:0] line_q [BATCH_LEN];
  logic [DIST_W-1:0] carry_q;
  logic [DIST_W-1:0] tail;
  logic [STEP_W-1:0] step_q;
  logic [PASS_W-1:0] pass_q;
  logic              busy_q;
  logic              done_q;
  logic              head_lt;

  // the shared compare unit
  assign head_lt = line_q[0] < carry_q;

  always_comb begin
    tail = line_q[0];
    if (step_q == STEP_LAST) begin
      tail = carry_q;
    end else if (step_q != '0) begin
      tail = head_lt ? line_q[0] : carry_q;
    end
  end

  // payload: line and carry
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      for (int k = 0; k < BATCH_LEN - 1; k++) begin
        line_q[k] <= line_q[k+1];
      end
      line_q[BATCH_LEN-1] <= sample_i;
    end else if (busy_q) begin
      for (int k = 0; k < BATCH_LEN - 1; k++) begin
        line_q[k] <= line_q[k+1];
      end
      line_q[BATCH_LEN-1] <= tail;
      if (step_q == '0) begin
        carry_q <= line_q[0];
      end else if (head_lt == 1'b0) begin
        // keep the larger value in the carry
        carry_q <= line_q[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      pass_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
        pass_q <= '0;
      end else if (busy_q) begin
        if (step_q == STEP_LAST) begin
          step_q <= '0;
          if (pass_q == PASS_LAST) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end else begin
            pass_q <= pass_q + 1'b1;
          end
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign median_o    = line_q[BATCH_LEN/2];

`ifndef SYNTHESIS
  a_no_push_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.push |-> !busy_q)
    else $error("sample pushed during sort");
  a_start_with_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start |-> ctrl_i.push)
    else $error("sort started without the closing sample");
  a_median_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (line_q[BATCH_LEN/2-1] <= line_q[BATCH_LEN/2]))
    else $error("line not ordered at median");
  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (!busy_q && $past(busy_q)))
    else $error("done without a finished sort");
`endif

endmodule

// ----- rtl/ranging_median_batch_filter.sv -----
// ----------------------------------------------------------------------------
// ranging_median_batch_filter
// Gathers distance samples in batches, sorts each batch for its upper median
// and tracks range, near runs and an average of near medians.
// ----------------------------------------------------------------------------
// Timing: after an input transfer a result passes ST_NEAR, then ST_DIV when an
//   average is formed, and ST_EMIT, which waits for the output register; a
//   batch-closing sample first waits in ST_SORT while the single comparator sorts.
// Throughput: s_axis_tready is high only in ST_IDLE, so no new sample is taken
//   until the previous result has been loaded into the output register.
// Reset: rst_ni clears all state but the sorter line and carry, threshold returns to 16000.
// ----------------------------------------------------------------------------
module ranging_median_batch_filter #(
  parameter int unsigned BATCH_LEN    = 10,
  parameter int unsigned NEAR_RUN_LEN = 5,
  parameter int unsigned AVG_LEN      = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // slave side
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [15:0]                       s_axis_tdata,  // [15:0] distance_sample
  // master side
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [15:0] filtered_distance, [31:16] range_low, [47:32] range_high,
  // [63:48] range_spread, [79:64] batch_count, [80] is_near,
  // [96:81] near_average, [103:97] zero
  output logic [103:0]                      m_axis_tdata,
  output logic [1:0]                        m_axis_tuser,  // [0] batch_done, [1] average_fresh
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rmbf_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [rmbf_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [rmbf_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import rmbf_pkg::*;

  localparam int unsigned FILL_W = $clog2(BATCH_LEN);
  localparam int unsigned AVG_W  = $clog2(AVG_LEN + 1);
  localparam int unsigned SUM_W  = DIST_W + AVG_W;
  localparam int unsigned DIV_S  = SUM_W + 2;
  localparam int unsigned PROD_W = SUM_W + DIV_S + 1;
  // reciprocal of AVG_LEN, rounded up: exact floor for every sum that occurs
  localparam logic [DIV_S:0] DIV_M = (DIV_S+1)'(((1 << DIV_S) + AVG_LEN - 1) / AVG_LEN);
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(BATCH_LEN - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SORT,
    ST_NEAR,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e            state_q;
  logic [FILL_W-1:0] fill_q;
  logic [DIST_W-1:0] median_q, low_q, high_q, batches_q, avg_value_q;
  logic              seeded_q;
  logic [RUN_W-1:0]  run_q;
  logic [AVG_W-1:0]  avg_fill_q;
  logic [SUM_W-1:0]  avg_sum_q, div_arg_q;
  logic              batch_done_q, near_q, fresh_q;

  logic              out_valid_q;
  logic [103:0]      out_data_q;
  logic [1:0]        out_user_q;

  logic [DIST_W-1:0] near_threshold;
  logic [DIST_W-1:0] sort_median;
  sort_ctrl_t        sort_ctrl;
  sort_stat_t        sort_stat;
  logic              in_xfer;

  // near-run step
  logic              near;
  logic [RUN_W-1:0]  run1, run2;
  logic [AVG_W-1:0]  fill1;
  logic [SUM_W-1:0]  sum1;
  logic [PROD_W-1:0] prod;

  rmbf_cfg u_cfg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .near_threshold_o (near_threshold)
  );

  rmbf_sorter #(
    .BATCH_LEN (BATCH_LEN)
  ) u_sorter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (sort_ctrl),
    .sample_i (s_axis_tdata),
    .stat_o   (sort_stat),
    .median_o (sort_median)
  );

  assign s_axis_tready   = (state_q == ST_IDLE);
  assign in_xfer         = s_axis_tvalid && s_axis_tready;
  assign sort_ctrl.push  = in_xfer;
  assign sort_ctrl.start = in_xfer && (fill_q == FILL_LAST);

  always_comb begin
    near  = median_q < near_threshold;
    run1  = '0;
    if (near) begin
      run1 = (run_q < RUN_MAX) ? run_q + 1'b1 : RUN_MAX;
    end
    run2  = (run1 < RUN_MAX) ? run1 + 1'b1 : RUN_MAX;
    fill1 = (near ? avg_fill_q : '0) + 1'b1;
    sum1  = (near ? avg_sum_q : '0) + SUM_W'(median_q);
  end

  assign prod = PROD_W'(div_arg_q) * PROD_W'(DIV_M);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      fill_q       <= '0;
      median_q     <= '0;
      low_q        <= '0;
      high_q       <= '0;
      seeded_q     <= 1'b0;
      batches_q    <= '0;
      run_q        <= '0;
      avg_fill_q   <= '0;
      avg_sum_q    <= '0;
      avg_value_q  <= '0;
      div_arg_q    <= '0;
      batch_done_q <= 1'b0;
      near_q       <= 1'b0;
      fresh_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
      out_user_q   <= '0;
    end else begin
      // in ST_EMIT the output register is reloaded instead
      if (out_valid_q && m_axis_tready && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            batch_done_q <= 1'b0;
            if (fill_q == FILL_LAST) begin
              fill_q  <= '0;
              state_q <= ST_SORT;
            end else begin
              fill_q  <= fill_q + 1'b1;
              state_q <= ST_NEAR;
            end
          end
        end
        ST_SORT: begin
          if (sort_stat.done) begin
            median_q     <= sort_median;
            batches_q    <= batches_q + 1'b1;
            batch_done_q <= 1'b1;
            seeded_q     <= 1'b1;
            if (!seeded_q) begin
              low_q  <= sort_median;
              high_q <= sort_median;
            end else begin
              if (sort_median < low_q) low_q <= sort_median;
              if (sort_median > high_q) high_q <= sort_median;
            end
            state_q <= ST_NEAR;
          end
        end
        ST_NEAR: begin
          near_q  <= near;
          fresh_q <= 1'b0;
          state_q <= ST_EMIT;
          if (run1 >= RUN_W'(NEAR_RUN_LEN)) begin
            run_q <= run2;
            if (fill1 >= AVG_W'(AVG_LEN)) begin
              // average due: clear the accumulator, divide next cycle
              div_arg_q  <= sum1;
              avg_fill_q <= '0;
              avg_sum_q  <= '0;
              fresh_q    <= 1'b1;
              state_q    <= ST_DIV;
            end else begin
              avg_fill_q <= fill1;
              avg_sum_q  <= sum1;
            end
          end else begin
            run_q <= run1;
            if (!near) begin
              avg_fill_q <= '0;
              avg_sum_q  <= '0;
            end
          end
        end
        ST_DIV: begin
          avg_value_q <= prod[DIV_S +: DIST_W];
          state_q     <= ST_EMIT;
        end
        ST_EMIT: begin
          // hold until the output register is free
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {7'd0, avg_value_q, near_q, batches_q, high_q - low_q,
                            high_q, low_q, median_q};
            out_user_q  <= {fresh_q, batch_done_q};
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule
